FILE: design/bsr_pkg.sv
// shared types and constants for the byte stack with rotate
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CAP_W  = 7;
   localparam int AMT_W  = 7;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_IGNORED = 2'd3;

   typedef enum logic [2:0] {
      ACT_PUSH     = 3'd0,
      ACT_POP      = 3'd1,
      ACT_PEEK     = 3'd2,
      ACT_DUP      = 3'd3,
      ACT_ROT_UP   = 3'd4,
      ACT_ROT_DOWN = 3'd5,
      ACT_PRINT    = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DUP_WR,
      ST_ROT_SAVE,
      ST_ROT_MOVE,
      ST_ROT_LAST,
      ST_PR_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] data;
      logic       dv;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

FILE: design/bsr_ram.sv
// stack entry memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module bsr_ram
   import bsr_pkg::*;
(
   input  wire logic        clock,
   input  wire ram_req_type req,
   output logic [7:0]       rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/bsr_ctrl.sv
// sequencer that steps the stack pointer unit and the entry memory
`timescale 1ns / 1ps
`default_nettype none

module bsr_ctrl
   import bsr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CAP_W-1:0] cap,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [2:0]       in_action,
   input  wire logic [7:0]       in_value,
   input  wire logic [AMT_W-1:0] in_amount,
   input  wire logic             out_free,
   output logic                  out_load,
   output result_type            out_res,
   output ram_req_type           ram_req,
   input  wire logic [7:0]       rd_data
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   action_type        act_ff, act_in;
   logic [7:0]        val_ff, val_in;
   logic [AMT_W-1:0]  amt_ff, amt_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [7:0]        moved_ff, moved_in;
   logic [1:0]        st_ff, st_in;
   logic              dv_ff, dv_in;
   logic              last_ff, last_in;

   logic              empty;
   logic              full;
   logic              rot_bad;
   logic              up;
   logic [ADDR_W-1:0] top_addr;
   logic [ADDR_W-1:0] base_addr;
   logic [ADDR_W-1:0] cur_step;
   logic [ADDR_W-1:0] cur_step2;

   // pointer unit
   assign empty     = (fill_ff == '0);
   assign full      = (fill_ff == CNT_W'(DEPTH)) || (CMP_W'(fill_ff) >= CMP_W'(cap));
   assign rot_bad   = (amt_ff == '0) || (CMP_W'(amt_ff) > CMP_W'(fill_ff));
   assign up        = (act_ff == ACT_ROT_UP);
   assign top_addr  = ADDR_W'(fill_ff - CNT_W'(1));
   assign base_addr = ADDR_W'(CMP_W'(fill_ff) - CMP_W'(amt_ff));
   assign cur_step  = up ? (cur_ff - ADDR_W'(1)) : (cur_ff + ADDR_W'(1));
   assign cur_step2 = up ? (cur_ff - ADDR_W'(2)) : (cur_ff + ADDR_W'(2));

   assign in_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (act_ff)
               ACT_PUSH, ACT_POP, ACT_PEEK: state_in = ST_EMIT;
               ACT_DUP:                     state_in = (empty || full) ? ST_EMIT : ST_DUP_WR;
               ACT_ROT_UP, ACT_ROT_DOWN:    state_in = rot_bad ? ST_EMIT : ST_ROT_SAVE;
               ACT_PRINT:                   state_in = empty ? ST_EMIT : ST_PR_READ;
               default:                     state_in = ST_IDLE;
            endcase
         end
         ST_DUP_WR:   state_in = ST_EMIT;
         ST_ROT_SAVE: state_in = (rem_ff == '0) ? ST_ROT_LAST : ST_ROT_MOVE;
         ST_ROT_MOVE: state_in = (rem_ff == CNT_W'(1)) ? ST_ROT_LAST : ST_ROT_MOVE;
         ST_ROT_LAST: state_in = ST_EMIT;
         ST_PR_READ:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = last_ff ? ST_IDLE : ST_PR_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      fill_in  = fill_ff;
      act_in   = act_ff;
      val_in   = val_ff;
      amt_in   = amt_ff;
      cur_in   = cur_ff;
      rem_in   = rem_ff;
      moved_in = moved_ff;
      st_in    = st_ff;
      dv_in    = dv_ff;
      last_in  = last_ff;
      out_load = 1'b0;
      ram_req  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               act_in = action_type'(in_action);
               val_in = in_value;
               amt_in = in_amount;
            end
         end
         ST_DECODE: begin
            st_in   = STATUS_OK;
            dv_in   = 1'b0;
            last_in = 1'b1;
            case (act_ff)
               ACT_PUSH: begin
                  if (full) begin
                     st_in = STATUS_FULL;
                  end else begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = ADDR_W'(fill_ff);
                     ram_req.wr_data = val_ff;
                     fill_in         = fill_ff + CNT_W'(1);
                  end
               end
               ACT_POP, ACT_PEEK: begin
                  if (empty) begin
                     st_in = STATUS_EMPTY;
                  end else begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = top_addr;
                     dv_in           = 1'b1;
                     if (act_ff == ACT_POP) begin
                        fill_in = fill_ff - CNT_W'(1);
                     end
                  end
               end
               ACT_DUP: begin
                  if (empty) begin
                     st_in = STATUS_EMPTY;
                  end else if (full) begin
                     st_in = STATUS_FULL;
                  end else begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = top_addr;
                  end
               end
               ACT_ROT_UP, ACT_ROT_DOWN: begin
                  if (rot_bad) begin
                     st_in = STATUS_IGNORED;
                  end else begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = up ? top_addr : base_addr;
                     cur_in          = up ? top_addr : base_addr;
                     rem_in          = CNT_W'(CMP_W'(amt_ff) - CMP_W'(1));
                  end
               end
               ACT_PRINT: begin
                  if (empty) begin
                     st_in = STATUS_EMPTY;
                  end else begin
                     cur_in = top_addr;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_DUP_WR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = ADDR_W'(fill_ff);
            ram_req.wr_data = rd_data;
            fill_in         = fill_ff + CNT_W'(1);
         end
         ST_ROT_SAVE: begin
            moved_in = rd_data;
            if (rem_ff != '0) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = cur_step;
            end
         end
         ST_ROT_MOVE: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = cur_ff;
            ram_req.wr_data = rd_data;
            cur_in          = cur_step;
            rem_in          = rem_ff - CNT_W'(1);
            if (rem_ff != CNT_W'(1)) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = cur_step2;
            end
         end
         ST_ROT_LAST: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = cur_ff;
            ram_req.wr_data = moved_ff;
         end
         ST_PR_READ: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = cur_ff;
            st_in           = STATUS_OK;
            dv_in           = 1'b1;
            last_in         = (cur_ff == '0);
         end
         ST_EMIT: begin
            out_load = out_free;
            if (out_free && !last_ff) begin
               cur_in = cur_ff - ADDR_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign out_res.status = st_ff;
   assign out_res.data   = dv_ff ? rd_data : 8'd0;
   assign out_res.dv     = dv_ff;
   assign out_res.last   = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      val_ff   <= val_in;
      amt_ff   <= amt_in;
      cur_ff   <= cur_in;
      rem_ff   <= rem_in;
      moved_ff <= moved_in;
      st_ff    <= st_in;
      dv_ff    <= dv_in;
      last_ff  <= last_in;
   end

endmodule

`default_nettype wire

FILE: design/byte_stack_with_rotate_core.sv
// top level of the byte stack with dup and rotate
//
// req channel: one transaction asks for one action (push, pop, peek, dup,
// up rotate, down rotate, print) on a stack of up to 64 bytes.
// rsp channel: each action gives one result transaction with tlast set,
// print gives one per element from top to bottom with tlast on the bottom
// one, or a single empty result; an unknown action gives none.
// csr channel: writes the capacity register, always ready; write only idle.
// push, pop, peek and an ignored or rejected action go from decode to the
// result; dup adds a write of the copied top, a rotate saves one end entry,
// moves the others and writes the saved one last, and print reads and
// emits each element in turn. the sequencer steps the entry memory, which
// has a write and a registered read port; a rotate moves one entry per cycle.
// req_tready is high only while the sequencer is idle, so one action is
// worked on at a time; a result waits in the output register while the
// next request is taken, and a stalled receiver holds the sequencer.
// reset empties the stack and sets capacity to 64; memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module byte_stack_with_rotate_core
   import bsr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // value [7:0], amount [14:8], zero [15]
   input  wire logic [2:0]  req_tuser,  // action [2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // status [1:0], data_out [9:2], zero [15:10]
   output logic             rsp_tuser,  // data_valid
   output logic             rsp_tlast,  // last
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_data   // capacity
);

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_res_ff, rsp_res_in;

   logic             out_free;
   logic             out_load;
   result_type       out_res;
   ram_req_type      ram_req;
   logic [7:0]       rd_data;

   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_data : cap_ff;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_res_in   = out_load ? out_res : rsp_res_ff;

   bsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cap       (cap_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_action (req_tuser),
      .in_value  (req_tdata[7:0]),
      .in_amount (req_tdata[14:8]),
      .out_free  (out_free),
      .out_load  (out_load),
      .out_res   (out_res),
      .ram_req   (ram_req),
      .rd_data   (rd_data)
   );

   bsr_ram u_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_res_ff.data, rsp_res_ff.status};
   assign rsp_tuser  = rsp_res_ff.dv;
   assign rsp_tlast  = rsp_res_ff.last;

endmodule

`default_nettype wire
